[design/timed_command_queue_assert.svh]
// Assertion helpers for the timed command queue.
`ifndef TIMED_COMMAND_QUEUE_ASSERT_SVH
`define TIMED_COMMAND_QUEUE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TCQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TCQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/tcq_pkg.sv]
`timescale 1ns / 1ps

package tcq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DELAY_WIDTH     = 32;
    localparam int unsigned ELAPSED_WIDTH   = 16;
    localparam int unsigned VALUE_WIDTH     = 16;
    localparam int unsigned OPQ_DEPTH       = 2;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        KIND_RESET  = 2'd0,
        KIND_SPEED  = 2'd1,
        KIND_ANGLE  = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_FIRE,
        ST_EMIT
    } t_bstate;

    typedef struct packed {
        t_func                          func;
        logic [DELAY_WIDTH-1:0]         delay_ms;
        logic                           do_reset;
        logic                           do_speed;
        logic                           do_angle;
        logic signed [VALUE_WIDTH-1:0]  speed_value;
        logic signed [VALUE_WIDTH-1:0]  angle_value;
        logic [ELAPSED_WIDTH-1:0]       elapsed_ms;
    } t_in_word;

    typedef struct packed {
        t_kind                          kind;
        logic signed [VALUE_WIDTH-1:0]  value;
        logic                           dropped;
        logic                           last;
    } t_out_word;

    // Stored command part of an entry.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  angle_value;
        logic signed [VALUE_WIDTH-1:0]  speed_value;
        logic                           do_angle;
        logic                           do_speed;
        logic                           do_reset;
    } t_cmd;

    typedef struct packed {
        t_func                          func;
        logic [DELAY_WIDTH-1:0]         delay_ms;
        t_cmd                           cmd;
        logic [ELAPSED_WIDTH-1:0]       elapsed_ms;
    } t_op;

    typedef struct packed {
        logic                           valid;
        t_op                            op;
    } t_op_chan;

endpackage

[design/timed_command_queue.sv]
`timescale 1ns / 1ps
`include "timed_command_queue_assert.svh"

// Timed command queue. Words pushed in are either new entries (func 0) or
// time ticks (func 1); they pass through a two-word input queue to a sequencer
// that owns the entry ring and the time accumulator. Every entry push returns
// one status word in the cycle after the sequencer takes it. A tick on an empty
// ring is popped and returns nothing; otherwise the sequencer takes it, reads
// the head from the entry RAM, does a saturating add, then compares and
// subtracts, and if the head entry fires it emits each of its command words as
// the output register frees. The tick pace is set by the single read port
// of the entry RAM and the one-word output register, which holds a word until
// it is popped while the input side keeps accepting up to two words.
module timed_command_queue #(
    parameter int unsigned QUEUE_DEPTH = tcq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tcq_pkg::t_in_word  i_data,
    output logic               empty,
    input  logic               pop,
    output tcq_pkg::t_out_word o_data
);

    import tcq_pkg::*;

    t_op_chan w_link;
    logic     w_op_pop;

    tcq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_data   (i_data),
        .o_link   (w_link),
        .i_op_pop (w_op_pop)
    );

    tcq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_link   (w_link),
        .o_op_pop (w_op_pop),
        .empty    (empty),
        .pop      (pop),
        .o_data   (o_data)
    );

    `TCQ_ASSERT(a_push_reaches_back, push && !full |=> w_link.valid, "pushed word not queued")
    `TCQ_ASSERT_ALWAYS(a_pop_needs_word, w_op_pop |-> w_link.valid, "pop of empty input queue")
    `TCQ_ASSERT(a_cmd_not_dropped, !empty && o_data.kind != KIND_STATUS |-> !o_data.dropped, "command marked dropped")
    `TCQ_ASSERT(a_status_is_last, !empty && o_data.kind == KIND_STATUS |-> o_data.last, "status not last")

endmodule

[design/tcq_ram.sv]
`timescale 1ns / 1ps

module tcq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/tcq_front.sv]
`timescale 1ns / 1ps

module tcq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  tcq_pkg::t_in_word i_data,
    output tcq_pkg::t_op_chan o_link,
    input  logic              i_op_pop
);

    import tcq_pkg::*;

    localparam int unsigned AW = $clog2(OPQ_DEPTH);
    localparam int unsigned CW = $clog2(OPQ_DEPTH + 1);

    t_op           r_slot [OPQ_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    t_op           w_op;
    logic          w_accept;

    always_comb begin
        w_op.func             = i_data.func;
        w_op.delay_ms         = i_data.delay_ms;
        w_op.cmd.do_reset     = i_data.do_reset;
        w_op.cmd.do_speed     = i_data.do_speed;
        w_op.cmd.do_angle     = i_data.do_angle;
        w_op.cmd.speed_value  = i_data.speed_value;
        w_op.cmd.angle_value  = i_data.angle_value;
        w_op.elapsed_ms       = i_data.elapsed_ms;
    end

    assign full     = (r_count == CW'(OPQ_DEPTH));
    assign w_accept = push && !full;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_accept) begin
            n_wr_ptr = (r_wr_ptr == AW'(OPQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_op_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(OPQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_accept && !i_op_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_accept && i_op_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot[r_wr_ptr] <= w_op;
        end
    end

    assign o_link.valid = (r_count != '0);
    assign o_link.op    = r_slot[r_rd_ptr];

endmodule

[design/tcq_back.sv]
`timescale 1ns / 1ps

module tcq_back #(
    parameter int unsigned QUEUE_DEPTH = tcq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcq_pkg::t_op_chan  i_link,
    output logic               o_op_pop,
    output logic               empty,
    input  logic               pop,
    output tcq_pkg::t_out_word o_data
);

    import tcq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMD_WIDTH = $bits(t_cmd);

    t_bstate                  r_state, n_state;
    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic [CW-1:0]            r_count, n_count;
    logic [DELAY_WIDTH-1:0]   r_acc, n_acc;
    logic [ELAPSED_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [2:0]               r_flags, n_flags;
    logic [VALUE_WIDTH-1:0]   r_speed, n_speed;
    logic [VALUE_WIDTH-1:0]   r_angle, n_angle;
    logic                     r_out_valid, n_out_valid;
    t_out_word                r_out, n_out;

    logic                     w_we;
    logic                     w_load_out;
    logic                     w_out_free;
    logic [DELAY_WIDTH-1:0]   w_rd_delay;
    logic [CMD_WIDTH-1:0]     w_rd_cmd_bits;
    t_cmd                     w_rd_cmd;
    logic [DELAY_WIDTH:0]     w_sum;
    logic [DELAY_WIDTH:0]     w_diff;

    tcq_ram #(
        .WIDTH (DELAY_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (i_link.op.delay_ms),
        .i_raddr (r_head),
        .o_rdata (w_rd_delay)
    );

    tcq_ram #(
        .WIDTH (CMD_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (i_link.op.cmd),
        .i_raddr (r_head),
        .o_rdata (w_rd_cmd_bits)
    );

    assign w_rd_cmd   = t_cmd'(w_rd_cmd_bits);
    assign w_out_free = !r_out_valid || pop;
    assign w_sum      = {1'b0, r_acc} + {{(DELAY_WIDTH + 1 - ELAPSED_WIDTH){1'b0}}, r_elapsed};
    assign w_diff     = {1'b0, r_acc} - {1'b0, w_rd_delay};

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_acc      = r_acc;
        n_elapsed  = r_elapsed;
        n_flags    = r_flags;
        n_speed    = r_speed;
        n_angle    = r_angle;
        n_out      = r_out;
        o_op_pop   = 1'b0;
        w_we       = 1'b0;
        w_load_out = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_link.valid) begin
                    if (i_link.op.func == FUNC_TICK) begin
                        o_op_pop = 1'b1;
                        if (r_count != '0) begin
                            n_elapsed = i_link.op.elapsed_ms;
                            n_state   = ST_READ;
                        end
                    end else if (w_out_free) begin
                        o_op_pop      = 1'b1;
                        w_load_out    = 1'b1;
                        n_out.kind    = KIND_STATUS;
                        n_out.value   = '0;
                        n_out.last    = 1'b1;
                        n_out.dropped = (r_count == CW'(QUEUE_DEPTH));
                        if (r_count != CW'(QUEUE_DEPTH)) begin
                            w_we    = 1'b1;
                            n_tail  = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc   = w_sum[DELAY_WIDTH] ? '1 : w_sum[DELAY_WIDTH-1:0];
                n_state = ST_FIRE;
            end
            ST_FIRE: begin
                n_state = ST_IDLE;
                if (!w_diff[DELAY_WIDTH]) begin
                    n_acc   = w_diff[DELAY_WIDTH-1:0];
                    n_flags = {w_rd_cmd.do_angle, w_rd_cmd.do_speed, w_rd_cmd.do_reset};
                    n_speed = w_rd_cmd.speed_value;
                    n_angle = w_rd_cmd.angle_value;
                    n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    if (n_flags != '0) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_load_out    = 1'b1;
                    n_out.dropped = 1'b0;
                    if (r_flags[0]) begin
                        n_out.kind  = KIND_RESET;
                        n_out.value = '0;
                        n_flags     = {r_flags[2:1], 1'b0};
                    end else if (r_flags[1]) begin
                        n_out.kind  = KIND_SPEED;
                        n_out.value = r_speed;
                        n_flags     = {r_flags[2], 2'b00};
                    end else begin
                        n_out.kind  = KIND_ANGLE;
                        n_out.value = r_angle;
                        n_flags     = 3'b000;
                    end
                    n_out.last = (n_flags == '0);
                    if (n_flags == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_acc       <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_flags     <= n_flags;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elapsed <= n_elapsed;
        r_speed   <= n_speed;
        r_angle   <= n_angle;
        r_out     <= n_out;
    end

    assign empty  = !r_out_valid;
    assign o_data = r_out;

endmodule
